@@ rtl/jel_pkg.sv @@
// shared types, constants and helpers of the jpeg exif segment locator
package jel_pkg;

  localparam int JEL_POSITION_BITS = 24;

  localparam logic [7:0] JEL_MARK_PREFIX = 8'hFF;
  localparam logic [7:0] JEL_MARK_SOI    = 8'hD8;
  localparam logic [7:0] JEL_MARK_SOS    = 8'hDA;
  localparam logic [7:0] JEL_MARK_EOI    = 8'hD9;
  localparam logic [7:0] JEL_MARK_APP1   = 8'hE1;

  localparam logic [2:0]  JEL_SIG_LAST_IDX = 3'd5;
  localparam logic [15:0] JEL_SIG_LEN      = 16'd6;
  localparam logic [15:0] JEL_MIN_SEG_LEN  = 16'd2;
  localparam logic [15:0] JEL_MIN_TIFF_LEN = 16'd8;
  localparam logic [31:0] JEL_OFFSET_LIMIT = 32'h00FF_FFFF;

  typedef enum logic [3:0] {
    PH_START0 = 4'd0,
    PH_START1 = 4'd1,
    PH_SCAN   = 4'd2,
    PH_MARKER = 4'd3,
    PH_LEN_HI = 4'd4,
    PH_LEN_LO = 4'd5,
    PH_HEADER = 4'd6,
    PH_SKIP   = 4'd7,
    PH_TIFF   = 4'd8,
    PH_DONE   = 4'd9
  } jel_phase_t;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       is_last;
  } jel_in_word_t;

  typedef struct packed {
    logic        found;
    logic [23:0] tiff_offset;
    logic [15:0] tiff_length;
  } jel_out_word_t;

  // "Exif\0\0"
  function automatic logic [7:0] jel_sig_byte(input logic [2:0] idx);
    logic [7:0] b;
    b = 8'h00;
    case (idx)
      3'd0:    b = 8'h45;
      3'd1:    b = 8'h78;
      3'd2:    b = 8'h69;
      3'd3:    b = 8'h66;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/jel_in_stage.sv @@
// input register of the locator
module jel_in_stage
  import jel_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  jel_in_word_t in_data,
  input  logic         take,
  output logic         valid,
  output jel_in_word_t data
);

  logic         valid_r;
  logic         valid_nxt;
  jel_in_word_t data_r;

  assign in_ready  = !valid_r || take;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= in_data;
    end
  end

  assign valid = valid_r;
  assign data  = data_r;

endmodule

@@ rtl/jel_scan.sv @@
// marker walk state machine and result decision, one byte per step
module jel_scan
  import jel_pkg::*;
#(
  parameter int POSITION_BITS = JEL_POSITION_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  jel_in_word_t  word,
  output logic          res_valid,
  output jel_out_word_t res
);

  jel_phase_t               phase_r, phase_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [7:0]               marker_r, marker_nxt;
  logic [7:0]               len_hi_r, len_hi_nxt;
  logic [15:0]              left_r, left_nxt;
  logic [2:0]               hdr_cnt_r, hdr_cnt_nxt;
  logic [23:0]              held_off_r, held_off_nxt;
  logic [15:0]              held_len_r, held_len_nxt;

  logic [7:0]  b;
  logic        last;
  logic [15:0] seg_len;
  logic [15:0] seg_rem;
  logic [15:0] left_dec;
  logic [15:0] left_sat;
  logic        sig_ok;
  logic [31:0] pos_ext;
  logic        pos_bad;
  logic        tiff_first;
  logic        emit;
  logic        hit;

  assign b          = word.file_byte;
  assign last       = word.is_last;
  assign seg_len    = {len_hi_r, b};
  assign seg_rem    = seg_len - JEL_MIN_SEG_LEN;
  assign left_dec   = left_r - 16'd1;
  assign left_sat   = (left_r != 16'd0) ? left_dec : 16'd0;
  assign sig_ok     = (b == jel_sig_byte(hdr_cnt_r));
  assign pos_ext    = 32'(pos_r);
  assign pos_bad    = (&pos_r) || (pos_ext > JEL_OFFSET_LIMIT);
  assign tiff_first = (left_r == held_len_r);

  // next state
  always_comb begin
    phase_nxt = phase_r;
    emit      = 1'b0;
    hit       = 1'b0;
    unique case (phase_r)
      PH_START0: begin
        if (b != JEL_MARK_PREFIX) emit = 1'b1;
        else phase_nxt = PH_START1;
      end
      PH_START1: begin
        if (b != JEL_MARK_SOI) emit = 1'b1;
        else phase_nxt = PH_SCAN;
      end
      PH_SCAN: begin
        if (b == JEL_MARK_PREFIX) phase_nxt = PH_MARKER;
      end
      PH_MARKER: begin
        if (b == JEL_MARK_SOS || b == JEL_MARK_EOI) emit = 1'b1;
        else phase_nxt = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        if (seg_len < JEL_MIN_SEG_LEN) emit = 1'b1;
        else if (marker_r == JEL_MARK_APP1 && seg_rem >= JEL_SIG_LEN) phase_nxt = PH_HEADER;
        else if (seg_rem == 16'd0) phase_nxt = PH_SCAN;
        else phase_nxt = PH_SKIP;
      end
      PH_HEADER: begin
        if (!sig_ok) begin
          phase_nxt = (left_dec == 16'd0) ? PH_SCAN : PH_SKIP;
        end else if (hdr_cnt_r == JEL_SIG_LAST_IDX) begin
          if (left_dec <= JEL_MIN_TIFF_LEN) emit = 1'b1;
          else phase_nxt = PH_TIFF;
        end
      end
      PH_SKIP: begin
        if (left_sat == 16'd0) phase_nxt = PH_SCAN;
      end
      PH_TIFF: begin
        if (tiff_first && pos_bad) begin
          emit = 1'b1;
        end else if (left_sat == 16'd0) begin
          emit = 1'b1;
          hit  = 1'b1;
        end
      end
      PH_DONE: begin
        phase_nxt = PH_DONE;
      end
      default: begin
        phase_nxt = PH_DONE;
      end
    endcase
    if (emit) phase_nxt = PH_DONE;
    if (last) phase_nxt = PH_START0;
  end

  // datapath and result
  always_comb begin
    marker_nxt   = marker_r;
    len_hi_nxt   = len_hi_r;
    left_nxt     = left_r;
    hdr_cnt_nxt  = hdr_cnt_r;
    held_off_nxt = held_off_r;
    held_len_nxt = held_len_r;
    unique case (phase_r)
      PH_MARKER: marker_nxt = b;
      PH_LEN_HI: len_hi_nxt = b;
      PH_LEN_LO: begin
        left_nxt    = seg_rem;
        hdr_cnt_nxt = 3'd0;
      end
      PH_HEADER: begin
        left_nxt = left_dec;
        if (sig_ok) begin
          hdr_cnt_nxt = hdr_cnt_r + 3'd1;
          if (hdr_cnt_r == JEL_SIG_LAST_IDX) held_len_nxt = left_dec;
        end
      end
      PH_SKIP: left_nxt = left_sat;
      PH_TIFF: begin
        if (tiff_first) held_off_nxt = pos_ext[23:0];
        left_nxt = left_sat;
      end
      default: begin
      end
    endcase

    if (last) pos_nxt = '0;
    else if (&pos_r) pos_nxt = pos_r;
    else pos_nxt = pos_r + 1'b1;

    res_valid       = step && (emit || (last && phase_r != PH_DONE));
    res.found       = hit;
    res.tiff_offset = hit ? held_off_nxt : 24'd0;
    res.tiff_length = hit ? held_len_r : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START0;
      pos_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      marker_r   <= marker_nxt;
      len_hi_r   <= len_hi_nxt;
      left_r     <= left_nxt;
      hdr_cnt_r  <= hdr_cnt_nxt;
      held_off_r <= held_off_nxt;
      held_len_r <= held_len_nxt;
    end
  end

endmodule

@@ rtl/jel_out_stage.sv @@
// result register of the locator
module jel_out_stage
  import jel_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          res_valid,
  input  jel_out_word_t res,
  output logic          slot_free,
  output logic          out_valid,
  input  logic          out_ready,
  output jel_out_word_t out_data
);

  logic          valid_r;
  logic          valid_nxt;
  jel_out_word_t data_r;

  assign slot_free = !valid_r || out_ready;
  assign valid_nxt = slot_free ? res_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && res_valid) begin
      data_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

@@ rtl/jpeg_exif_segment_locator.sv @@
// top level of the jpeg exif segment locator
// usage:
//   in channel: one file byte per word (in_data.file_byte) with in_data.is_last
//   set on the final byte of each file, valid/ready handshake
//   out channel: exactly one word per file (found, tiff_offset, tiff_length),
//   given on the byte where the outcome is settled; offset and length are 0
//   when found is 0
// throughput: one byte per cycle, sustained, as long as out_ready is not held low
// path: an accepted byte waits in the input register, is decoded by the scanner,
//   and its result is registered in the output register once that has room
// stall: a held result stays in the output register; the byte behind it waits
//   in the input register, and in_ready drops once both are occupied
// reset: synchronous rst_n clears both stages and returns the scanner to the
//   start of a file with the byte position at zero
// the byte position saturates at 2^POSITION_BITS - 1
module jpeg_exif_segment_locator
  import jel_pkg::*;
#(
  parameter int POSITION_BITS = JEL_POSITION_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  jel_in_word_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output jel_out_word_t out_data
);

  logic          stg_valid;
  jel_in_word_t  stg_data;
  logic          slot_free;
  logic          step;
  logic          res_valid;
  jel_out_word_t res;

  assign step = stg_valid && slot_free;

  jel_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .take     (step),
    .valid    (stg_valid),
    .data     (stg_data)
  );

  jel_scan #(
    .POSITION_BITS (POSITION_BITS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .word      (stg_data),
    .res_valid (res_valid),
    .res       (res)
  );

  jel_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
